/* rtl/core/opu_pkg.sv */
package opu_pkg;

    localparam int unsigned STEPS_DEFAULT = 16;
    localparam int unsigned XW = 40;
    localparam int unsigned GW = 31;
    localparam int unsigned HALF_W = XW / 2;
    localparam logic [30:0] MIN_TRANS_RESET = 31'd655;
    localparam logic [61:0] MIN_SQ_RESET = 62'(MIN_TRANS_RESET * MIN_TRANS_RESET);
    localparam logic REG_MIN_TRANS = 1'b0;

    localparam logic [31:0] ATAN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [31:0] particle_x;
        logic signed [31:0] particle_y;
        logic signed [15:0] particle_yaw;
        logic signed [31:0] new_odom_x;
        logic signed [31:0] new_odom_y;
        logic signed [15:0] new_odom_yaw;
        logic signed [31:0] old_odom_x;
        logic signed [31:0] old_odom_y;
        logic signed [15:0] old_odom_yaw;
    } opu_in_t;

    typedef struct packed {
        logic signed [31:0] moved_x;
        logic signed [31:0] moved_y;
        logic signed [15:0] moved_yaw;
    } opu_out_t;

    typedef struct packed {
        logic               vld;
        logic               eq;
        logic [31:0]        px;
        logic [31:0]        py;
        logic [15:0]        yaw_out;
        logic [15:0]        pyaw;
        logic [15:0]        nyaw;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } opu_diff_t;

    typedef struct packed {
        logic                 vld;
        logic                 eq;
        logic                 big;
        logic [31:0]          px;
        logic [31:0]          py;
        logic [15:0]          yaw_out;
        logic [15:0]          pyaw;
        logic [15:0]          nyaw;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
    } opu_vec_t;

    typedef struct packed {
        logic                 vld;
        logic                 eq;
        logic [31:0]          px;
        logic [31:0]          py;
        logic [15:0]          yaw_out;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [33:0]   zz;
    } opu_rot_t;

    typedef struct packed {
        logic                   vld;
        logic                   eq;
        logic [31:0]            px;
        logic [31:0]            py;
        logic [15:0]            yaw_out;
        logic                   negx;
        logic                   negy;
        logic [HALF_W+GW-1:0]   xlo;
        logic [HALF_W+GW-1:0]   xhi;
        logic [HALF_W+GW-1:0]   ylo;
        logic [HALF_W+GW-1:0]   yhi;
    } opu_mul_t;

    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [GW-1:0] inv_gain_sq(int unsigned steps);
        logic [63:0] v;
        logic [63:0] r;
        v = 64'd1 << 62;
        for (int unsigned i = 0; i < steps; i++)
        begin
            v = v - udiv64(v, (64'd1 << (2 * i)) + 64'd1);
        end
        r = (v + (64'd1 << 31)) >> 32;
        return r[GW-1:0];
    endfunction

endpackage

/* rtl/core/odometry_pose_update_core.sv */
// Odometry pose update: one particle pose and two odometry poses enter per word,
// one updated pose leaves per word. The core is a pipeline of these stages
// from start to done: two setup stages, one stage per vectoring CORDIC
// step, one stage to form the heading, one stage per rotation CORDIC step,
// and two stages for the split gain multiply and final add. A new word may be
// started every cycle; busy stays low, and done marks each result for exactly
// one cycle with no way to hold it. Write min_translation over the APB port
// only while no word is in flight.
module odometry_pose_update_core #(
    parameter int unsigned CORDIC_STEPS = opu_pkg::STEPS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  opu_pkg::opu_in_t item,
    output logic             done,
    output opu_pkg::opu_out_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned N  = CORDIC_STEPS;
    localparam int unsigned XW = opu_pkg::XW;
    localparam int unsigned HW = opu_pkg::HALF_W;
    localparam int unsigned GW = opu_pkg::GW;
    localparam logic [GW-1:0] G = opu_pkg::inv_gain_sq(N);

    logic [30:0]        min_reg;
    logic [61:0]        min_sq_reg;
    opu_pkg::opu_diff_t diff_reg;
    opu_pkg::opu_diff_t diff_next;
    logic [61:0]        sqx_reg;
    logic [61:0]        sqy_reg;
    logic [61:0]        sqx_next;
    logic [61:0]        sqy_next;
    opu_pkg::opu_vec_t  vec_reg  [N+1];
    opu_pkg::opu_vec_t  vec_next [N+1];
    opu_pkg::opu_rot_t  rot_reg  [N+1];
    opu_pkg::opu_rot_t  rot_next [N+1];
    opu_pkg::opu_mul_t  mul_reg;
    opu_pkg::opu_mul_t  mul_next;
    opu_pkg::opu_out_t  result_reg;
    opu_pkg::opu_out_t  result_next;
    logic               done_reg;
    logic               cfg_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == opu_pkg::REG_MIN_TRANS);
    assign prdata = (paddr[2] == opu_pkg::REG_MIN_TRANS) ? {1'b0, min_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= opu_pkg::MIN_TRANS_RESET;
            min_sq_reg <= opu_pkg::MIN_SQ_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                min_reg <= pwdata[30:0];
            end
            min_sq_reg <= min_reg * min_reg;
        end
    end

    always_comb
    begin
        diff_next.vld     = start;
        diff_next.eq      = (item.new_odom_x == item.old_odom_x)
                         && (item.new_odom_y == item.old_odom_y)
                         && (item.new_odom_yaw == item.old_odom_yaw);
        diff_next.px      = item.particle_x;
        diff_next.py      = item.particle_y;
        diff_next.yaw_out = 16'(item.particle_yaw + item.old_odom_yaw - item.new_odom_yaw);
        diff_next.pyaw    = item.particle_yaw;
        diff_next.nyaw    = item.new_odom_yaw;
        diff_next.dx      = 33'(item.old_odom_x) - 33'(item.new_odom_x);
        diff_next.dy      = 33'(item.old_odom_y) - 33'(item.new_odom_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
        end
        else
        begin
            diff_reg <= diff_next;
        end
    end

    always_comb
    begin
        logic [32:0]          adx;
        logic [32:0]          ady;
        logic signed [XW-1:0] ex;
        logic signed [XW-1:0] ey;
        adx = diff_reg.dx[32] ? 33'(-diff_reg.dx) : diff_reg.dx;
        ady = diff_reg.dy[32] ? 33'(-diff_reg.dy) : diff_reg.dy;
        ex  = XW'(diff_reg.dx);
        ey  = XW'(diff_reg.dy);
        sqx_next = adx[30:0] * adx[30:0];
        sqy_next = ady[30:0] * ady[30:0];
        vec_next[0].vld     = diff_reg.vld;
        vec_next[0].eq      = diff_reg.eq;
        vec_next[0].big     = adx[32] | adx[31] | ady[32] | ady[31];
        vec_next[0].px      = diff_reg.px;
        vec_next[0].py      = diff_reg.py;
        vec_next[0].yaw_out = diff_reg.yaw_out;
        vec_next[0].pyaw    = diff_reg.pyaw;
        vec_next[0].nyaw    = diff_reg.nyaw;
        vec_next[0].x       = diff_reg.dx[32] ? -ex : ex;
        vec_next[0].y       = diff_reg.dx[32] ? -ey : ey;
        vec_next[0].z       = diff_reg.dx[32] ? 32'h8000_0000 : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg[0] <= '0;
            sqx_reg    <= '0;
            sqy_reg    <= '0;
        end
        else
        begin
            vec_reg[0] <= vec_next[0];
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        always_comb
        begin
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            xs = vec_reg[k].x >>> k;
            ys = vec_reg[k].y >>> k;
            vec_next[k+1] = vec_reg[k];
            if (k == 0)
            begin
                vec_next[k+1].big = vec_reg[k].big
                                 || ({1'b0, sqx_reg} + {1'b0, sqy_reg} > {1'b0, min_sq_reg});
            end
            if (!vec_reg[k].y[XW-1])
            begin
                vec_next[k+1].x = vec_reg[k].x + ys;
                vec_next[k+1].y = vec_reg[k].y - xs;
                vec_next[k+1].z = vec_reg[k].z + opu_pkg::ATAN[k];
            end
            else
            begin
                vec_next[k+1].x = vec_reg[k].x - ys;
                vec_next[k+1].y = vec_reg[k].y + xs;
                vec_next[k+1].z = vec_reg[k].z - opu_pkg::ATAN[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vec_reg[k+1] <= '0;
            end
            else
            begin
                vec_reg[k+1] <= vec_next[k+1];
            end
        end
    end

    always_comb
    begin
        logic [31:0] rot1;
        logic [31:0] a;
        logic [31:0] t;
        rot1 = vec_reg[N].big ? (vec_reg[N].z - {vec_reg[N].nyaw, 16'd0}) : 32'd0;
        a    = {vec_reg[N].pyaw, 16'd0} + rot1;
        t    = a + 32'h4000_0000;
        rot_next[0].vld     = vec_reg[N].vld;
        rot_next[0].eq      = vec_reg[N].eq;
        rot_next[0].px      = vec_reg[N].px;
        rot_next[0].py      = vec_reg[N].py;
        rot_next[0].yaw_out = vec_reg[N].yaw_out;
        rot_next[0].y       = '0;
        if (t[31])
        begin
            rot_next[0].x  = -vec_reg[N].x;
            rot_next[0].zz = 34'($signed(a + 32'h8000_0000));
        end
        else
        begin
            rot_next[0].x  = vec_reg[N].x;
            rot_next[0].zz = 34'($signed(a));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= '0;
        end
        else
        begin
            rot_reg[0] <= rot_next[0];
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_rot
        always_comb
        begin
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            xs = rot_reg[k].x >>> k;
            ys = rot_reg[k].y >>> k;
            rot_next[k+1] = rot_reg[k];
            if (!rot_reg[k].zz[33])
            begin
                rot_next[k+1].x  = rot_reg[k].x - ys;
                rot_next[k+1].y  = rot_reg[k].y + xs;
                rot_next[k+1].zz = rot_reg[k].zz - $signed({2'b00, opu_pkg::ATAN[k]});
            end
            else
            begin
                rot_next[k+1].x  = rot_reg[k].x + ys;
                rot_next[k+1].y  = rot_reg[k].y - xs;
                rot_next[k+1].zz = rot_reg[k].zz + $signed({2'b00, opu_pkg::ATAN[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rot_reg[k+1] <= '0;
            end
            else
            begin
                rot_reg[k+1] <= rot_next[k+1];
            end
        end
    end

    always_comb
    begin
        logic [XW-1:0] mx;
        logic [XW-1:0] my;
        mx = rot_reg[N].x[XW-1] ? XW'(-rot_reg[N].x) : XW'(rot_reg[N].x);
        my = rot_reg[N].y[XW-1] ? XW'(-rot_reg[N].y) : XW'(rot_reg[N].y);
        mul_next.vld     = rot_reg[N].vld;
        mul_next.eq      = rot_reg[N].eq;
        mul_next.px      = rot_reg[N].px;
        mul_next.py      = rot_reg[N].py;
        mul_next.yaw_out = rot_reg[N].yaw_out;
        mul_next.negx    = rot_reg[N].x[XW-1];
        mul_next.negy    = rot_reg[N].y[XW-1];
        mul_next.xlo     = mx[HW-1:0] * G;
        mul_next.xhi     = mx[XW-1:HW] * G;
        mul_next.ylo     = my[HW-1:0] * G;
        mul_next.yhi     = my[XW-1:HW] * G;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= '0;
        end
        else
        begin
            mul_reg <= mul_next;
        end
    end

    always_comb
    begin
        logic [63:0] sx;
        logic [63:0] sy;
        logic [31:0] rx;
        logic [31:0] ry;
        sx = 64'(mul_reg.xlo) + (64'(mul_reg.xhi) << HW) + (64'd1 << 29);
        sy = 64'(mul_reg.ylo) + (64'(mul_reg.yhi) << HW) + (64'd1 << 29);
        rx = mul_reg.negx ? -sx[61:30] : sx[61:30];
        ry = mul_reg.negy ? -sy[61:30] : sy[61:30];
        result_next.moved_x   = mul_reg.eq ? mul_reg.px : mul_reg.px + rx;
        result_next.moved_y   = mul_reg.eq ? mul_reg.py : mul_reg.py + ry;
        result_next.moved_yaw = mul_reg.yaw_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg   <= mul_reg.vld;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/opu_checker.sv */
module opu_checker #(
    parameter int unsigned CORDIC_STEPS = opu_pkg::STEPS_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input opu_pkg::opu_in_t  item,
    input logic              done,
    input opu_pkg::opu_out_t result
);

    localparam int unsigned LAT = 2 * CORDIC_STEPS + 5;

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word produced no result");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.moved_yaw
            == $past(16'(item.particle_yaw + item.old_odom_yaw - item.new_odom_yaw), LAT))
        else $error("heading mismatch");

    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(item.new_odom_x == item.old_odom_x
            && item.new_odom_y == item.old_odom_y
            && item.new_odom_yaw == item.old_odom_yaw, LAT))
        |-> (result.moved_x == $past(item.particle_x, LAT)
            && result.moved_y == $past(item.particle_y, LAT)))
        else $error("unchanged odometry moved the particle");

endmodule

bind odometry_pose_update_core opu_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_opu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
